/* hw/rtl/r2fft_pkg.sv */
// Shared types and constants for the radix-2 FFT with half swap.
// Depends on nothing; used by every module in hw/rtl.
package r2fft_pkg;
	localparam int SampleW = 16;
	localparam int ResultW = 22;
	localparam int AccW    = 26;
	localparam int TwW     = 17;
	localparam int ProdW   = 38;

	typedef logic signed [AccW-1:0] acc_t;
	typedef logic signed [TwW-1:0]  tw_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_BFY_RD, ST_BFY_MUL, ST_BFY_WR, ST_EMIT
	} core_state_t;

	// round(32768*sin(pi*k/32)), k = 0..16
	function automatic tw_t quarter_sine(input logic [4:0] k);
		case (k)
			5'd0:  quarter_sine = 17'sd0;
			5'd1:  quarter_sine = 17'sd3212;
			5'd2:  quarter_sine = 17'sd6393;
			5'd3:  quarter_sine = 17'sd9512;
			5'd4:  quarter_sine = 17'sd12540;
			5'd5:  quarter_sine = 17'sd15447;
			5'd6:  quarter_sine = 17'sd18205;
			5'd7:  quarter_sine = 17'sd20788;
			5'd8:  quarter_sine = 17'sd23170;
			5'd9:  quarter_sine = 17'sd25330;
			5'd10: quarter_sine = 17'sd27246;
			5'd11: quarter_sine = 17'sd28899;
			5'd12: quarter_sine = 17'sd30274;
			5'd13: quarter_sine = 17'sd31357;
			5'd14: quarter_sine = 17'sd32138;
			5'd15: quarter_sine = 17'sd32610;
			default: quarter_sine = 17'sd32768;
		endcase
	endfunction

	// Cosine of angle pi*idx/32, idx in 0..31
	function automatic tw_t tw_cos(input logic [4:0] idx);
		if (idx <= 5'd16) tw_cos = quarter_sine(5'd16 - idx);
		else tw_cos = -quarter_sine(idx - 5'd16);
	endfunction

	function automatic tw_t tw_sin(input logic [4:0] idx);
		if (idx <= 5'd16) tw_sin = quarter_sine(idx);
		else tw_sin = quarter_sine(5'd0 - idx);
	endfunction

	// floor(v/32768 + 1/2) for a 38-bit product sum
	function automatic acc_t round_q15(input logic signed [ProdW-1:0] v);
		logic signed [ProdW-1:0] t;
		t = v + 38'sd16384;
		round_q15 = acc_t'(t >>> 15);
	endfunction

	function automatic logic [ResultW-1:0] sat22(input acc_t v);
		if (v > acc_t'(2097151)) sat22 = 22'h1FFFFF;
		else if (v < -acc_t'(2097152)) sat22 = 22'h200000;
		else sat22 = v[ResultW-1:0];
	endfunction
endpackage

/* hw/rtl/r2fft_front.sv */
// Input front end: two-entry sample queue between port and core.
// Depends on r2fft_pkg.
module r2fft_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [r2fft_pkg::SampleW-1:0] in_re,
	input  logic signed [r2fft_pkg::SampleW-1:0] in_im,
	output logic q_valid,
	input  logic q_ready,
	output logic signed [r2fft_pkg::SampleW-1:0] q_re,
	output logic signed [r2fft_pkg::SampleW-1:0] q_im
);
	import r2fft_pkg::*;

	logic [SampleW-1:0] re_q [2];
	logic [SampleW-1:0] im_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;
	assign q_re = re_q[rp_q];
	assign q_im = im_q[rp_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			re_q[wp_q] <= in_re;
			im_q[wp_q] <= in_im;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hw/rtl/r2fft_core.sv */
// Back end: sample buffer, butterfly sequencer, shifted emit with output register.
// Depends on r2fft_pkg.
module r2fft_core #(
	parameter int POINTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic direction,
	input  logic s_valid,
	output logic s_ready,
	input  logic signed [r2fft_pkg::SampleW-1:0] s_re,
	input  logic signed [r2fft_pkg::SampleW-1:0] s_im,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [r2fft_pkg::ResultW-1:0] out_re,
	output logic signed [r2fft_pkg::ResultW-1:0] out_im,
	output logic out_last
);
	import r2fft_pkg::*;

	localparam int Bits = $clog2(POINTS);
	localparam int Half = POINTS / 2;

	core_state_t state_q, state_d;
	acc_t mem_re [POINTS];
	acc_t mem_im [POINTS];

	logic [Bits-1:0] ld_q;
	logic [Bits-1:0] stage_q;   // log2 of span
	logic [Bits-1:0] bf_q;      // butterfly index within stage
	logic [Bits-1:0] em_q;
	acc_t ar_q, ai_q, br_q, bi_q;
	tw_t wr_q, wi_q;
	logic signed [ProdW-1:0] pr_s2, pi_s2;
	logic ov_q;
	logic [ResultW-1:0] ore_q, oim_q;
	logic olast_q;

	logic [Bits-1:0] span, hh, jj, kk, rev, eaddr, ra;
	logic [4:0] tidx;
	logic take, emit_go, bf_last;

	// Butterfly addressing: j = group*2*span + h, k = j + span
	always_comb begin
		span = Bits'(1) << stage_q;
		hh = bf_q & (span - Bits'(1));
		jj = ((bf_q - hh) << 1) | hh;
		kk = jj | span;
		tidx = 5'(6'(hh) << (5 - stage_q));
		for (int b = 0; b < Bits; b++) rev[b] = ld_q[Bits-1-b];
		eaddr = em_q ^ Bits'(Half);
		// first read port is shared by butterfly reads and emit
		ra = (state_q == ST_EMIT) ? eaddr : jj;
		bf_last = (bf_q == Bits'(Half - 1));
	end

	assign s_ready = (state_q == ST_LOAD);
	assign take = s_valid && s_ready;
	assign emit_go = (state_q == ST_EMIT) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign out_re = ore_q;
	assign out_im = oim_q;
	assign out_last = olast_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:    if (take && ld_q == Bits'(POINTS - 1)) state_d = ST_BFY_RD;
			ST_BFY_RD:  state_d = ST_BFY_MUL;
			ST_BFY_MUL: state_d = ST_BFY_WR;
			ST_BFY_WR:  state_d = (bf_last && stage_q == Bits'(Bits - 1)) ? ST_EMIT : ST_BFY_RD;
			ST_EMIT:    if (emit_go && em_q == Bits'(POINTS - 1)) state_d = ST_LOAD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// Buffer memory: loads in bit-reversed order, butterfly writes
	always_ff @(posedge clk) begin
		if (take) begin
			mem_re[rev] <= acc_t'(s_re);
			mem_im[rev] <= acc_t'(s_im);
		end else if (state_q == ST_BFY_WR) begin
			mem_re[jj] <= ar_q + round_q15(pr_s2);
			mem_im[jj] <= ai_q + round_q15(pi_s2);
			mem_re[kk] <= ar_q - round_q15(pr_s2);
			mem_im[kk] <= ai_q - round_q15(pi_s2);
		end
		if (state_q == ST_BFY_RD) begin
			ar_q <= mem_re[ra];
			ai_q <= mem_im[ra];
			br_q <= mem_re[kk];
			bi_q <= mem_im[kk];
			wr_q <= tw_cos(tidx);
			wi_q <= direction ? -tw_sin(tidx) : tw_sin(tidx);
		end
		if (state_q == ST_BFY_MUL) begin
			pr_s2 <= ProdW'(br_q) * ProdW'(wr_q) - ProdW'(bi_q) * ProdW'(wi_q);
			pi_s2 <= ProdW'(bi_q) * ProdW'(wr_q) + ProdW'(br_q) * ProdW'(wi_q);
		end
		if (emit_go) begin
			ore_q <= sat22(mem_re[ra]);
			oim_q <= sat22(mem_im[ra]);
			olast_q <= (em_q == Bits'(POINTS - 1));
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ld_q <= '0;
			stage_q <= '0;
			bf_q <= '0;
			em_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) ld_q <= ld_q + Bits'(1);
			if (state_q == ST_BFY_WR) begin
				bf_q <= bf_q + Bits'(1);
				if (bf_last) begin
					bf_q <= '0;
					stage_q <= (stage_q == Bits'(Bits - 1)) ? '0 : stage_q + Bits'(1);
				end
			end
			if (emit_go) begin
				em_q <= em_q + Bits'(1);
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule

/* hw/rtl/radix2_complex_fft_shifted.sv */
// Top level: radix-2 DIT FFT with half swap and direction register.
// Depends on r2fft_pkg, r2fft_front, r2fft_core.
//
//  channel   handshake                      payload
//  sample    sample_valid / sample_ready    sample_re, sample_im
//  result    result_valid / result_ready    result_re, result_im, final_bin
//  config    cfg_valid / cfg_ready          cfg_data (direction)
//
// A frame of POINTS samples loads at one per cycle while samples are offered,
// then the core runs (POINTS/2)*log2(POINTS) butterflies, each in a read, a
// multiply and a write state, through one complex multiplier, then emits POINTS
// bins at one per cycle while result_ready holds, through an output register.
// While the core computes or emits, the two-entry sample queue takes two
// samples, then drops sample_ready. Reset clears control, direction forward.
module radix2_complex_fft_shifted #(
	parameter int POINTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic signed [r2fft_pkg::SampleW-1:0] sample_re,
	input  logic signed [r2fft_pkg::SampleW-1:0] sample_im,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [r2fft_pkg::ResultW-1:0] result_re,
	output logic signed [r2fft_pkg::ResultW-1:0] result_im,
	output logic final_bin,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import r2fft_pkg::*;

	logic direction_q;
	logic q_valid, q_ready;
	logic signed [SampleW-1:0] q_re, q_im;

	assign cfg_ready = 1'b1;

	// Direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) direction_q <= 1'b1;
		else if (cfg_valid && cfg_ready) direction_q <= cfg_data;
	end

	r2fft_front u_front (
		.clk, .arst_n,
		.in_valid(sample_valid), .in_ready(sample_ready),
		.in_re(sample_re), .in_im(sample_im),
		.q_valid, .q_ready, .q_re, .q_im
	);

	r2fft_core #(.POINTS(POINTS)) u_core (
		.clk, .arst_n,
		.direction(direction_q),
		.s_valid(q_valid), .s_ready(q_ready), .s_re(q_re), .s_im(q_im),
		.out_valid(result_valid), .out_ready(result_ready),
		.out_re(result_re), .out_im(result_im), .out_last(final_bin)
	);
endmodule
